// File: design/shot_heat_budget_gate_top_defines.svh
// Assertion macros for the shot heat budget gate.
`ifndef SHOT_HEAT_BUDGET_GATE_TOP_DEFINES_SVH
`define SHOT_HEAT_BUDGET_GATE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SHBG_ASSERT_IMPLY(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("shbg: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SHBG_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("shbg: next-cycle check failed");

`endif

// File: design/shbg_pkg.sv
// Shared types and constants of the shot heat budget gate.
package shbg_pkg;

   localparam int unsigned SPEED_W     = 16;
   localparam int unsigned TARGET_W    = 15;
   localparam int unsigned HEAT_W      = 16;
   localparam int unsigned COOL_W      = 16;
   localparam int unsigned OWN_HEAT_W  = 24;
   // decay per tick tops out at 65535 * 1000 / 200 over the scale range
   localparam int unsigned DECAY_W     = 19;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned REQ_TDATA_W = 40;
   localparam int unsigned RSP_TDATA_W = 24;

   localparam logic [TARGET_W-1:0] TARGET_RESET = 15'd5700;
   localparam logic [COOL_W-1:0]   COOL_RESET   = 16'd40;
   localparam logic [HEAT_W-1:0]   LIMIT_RESET  = 16'd240;

   localparam int unsigned ARM_WINDOW    = 300;
   localparam int unsigned SHOT_HEAT     = 100;
   localparam int unsigned FIRE_MARGIN   = 150;
   localparam int unsigned TICKS_PER_SEC = 200;
   // shot when |speed| < 9/10 of target
   localparam int unsigned SHOT_NUM      = 9;
   localparam int unsigned SHOT_DEN      = 10;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_SPEED = 2'd0,
      CSR_COOLING_RATE = 2'd1,
      CSR_HEAT_CEILING = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                      enabled;
      logic signed [SPEED_W-1:0] speed;
      logic [HEAT_W-1:0]         referee_heat;
   } item_type;

   typedef struct packed {
      logic [TARGET_W-1:0] target_speed;
      logic [HEAT_W-1:0]   heat_ceiling;
      logic [DECAY_W-1:0]  decay;
   } cfg_type;

endpackage

// File: design/shbg_cdiv.sv
// Two-stage divide by a constant: reciprocal multiply, then one-step correction.
module shbg_cdiv #(
   parameter int unsigned WIDTH   = 24,
   parameter int unsigned DIVISOR = 200
) (
   input  logic             clock,
   input  logic             en_mul,
   input  logic             en_fix,
   input  logic [WIDTH-1:0] dividend,
   output logic [WIDTH-1:0] quotient
);

   localparam int unsigned SHIFT  = WIDTH + $clog2(DIVISOR);
   localparam int unsigned PROD_W = 2 * WIDTH + 1;
   localparam int unsigned BACK_W = WIDTH + $clog2(DIVISOR + 1);
   // floor(2^SHIFT / DIVISOR) fits WIDTH+1 bits; estimate is q or q-1
   localparam logic [WIDTH:0] RECIP = (WIDTH + 1)'((65'd1 << SHIFT) / DIVISOR);

   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [WIDTH-1:0]  x_ff;
   logic [WIDTH-1:0]  quot_ff, quot_in;
   logic [WIDTH-1:0]  q_est;
   logic [BACK_W-1:0] back;
   logic [BACK_W-1:0] rem;

   assign prod_in = PROD_W'(dividend) * PROD_W'(RECIP);

   always_comb begin
      q_est   = WIDTH'(prod_ff >> SHIFT);
      back    = BACK_W'(q_est) * BACK_W'(DIVISOR);
      rem     = BACK_W'(x_ff) - back;
      quot_in = (rem >= BACK_W'(DIVISOR)) ? q_est + WIDTH'(1) : q_est;
   end

   always_ff @(posedge clock) begin
      if (en_mul) begin
         prod_ff <= prod_in;
         x_ff    <= dividend;
      end
      if (en_fix) begin
         quot_ff <= quot_in;
      end
   end

   assign quotient = quot_ff;

endmodule

// File: design/shbg_cfg.sv
// Configuration registers and the per-tick cooling amount.
module shbg_cfg #(
   parameter int unsigned HEAT_FRAC_SCALE = 200
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [shbg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [shbg_pkg::COOL_W-1:0]        csr_wdata,
   output shbg_pkg::cfg_type                  cfg,
   output logic                               busy
);

   localparam int unsigned PROD_W = shbg_pkg::COOL_W + $clog2(HEAT_FRAC_SCALE + 1);
   localparam logic [PROD_W-1:0] COOL_RESET_PROD =
      PROD_W'(shbg_pkg::COOL_RESET * HEAT_FRAC_SCALE);

   typedef enum logic [1:0] {
      DEC_IDLE,
      DEC_MUL,
      DEC_FIX
   } dec_state_type;

   dec_state_type                       state_ff;
   logic [shbg_pkg::TARGET_W-1:0]       target_ff;
   logic [shbg_pkg::HEAT_W-1:0]         limit_ff;
   logic [PROD_W-1:0]                   cool_prod_ff;
   logic [PROD_W-1:0]                   decay_q;
   logic                                wr;

   assign busy      = (state_ff != DEC_IDLE);
   assign csr_ready = !busy;
   assign wr        = csr_valid && csr_ready;

   // cooling * scale is registered, then divided by ticks per second
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= DEC_MUL;
         target_ff    <= shbg_pkg::TARGET_RESET;
         limit_ff     <= shbg_pkg::LIMIT_RESET;
         cool_prod_ff <= COOL_RESET_PROD;
      end else begin
         case (state_ff)
            DEC_IDLE: begin
               if (wr) begin
                  case (csr_index)
                     shbg_pkg::CSR_TARGET_SPEED: begin
                        target_ff <= csr_wdata[shbg_pkg::TARGET_W-1:0];
                     end
                     shbg_pkg::CSR_COOLING_RATE: begin
                        cool_prod_ff <= PROD_W'(csr_wdata) * PROD_W'(HEAT_FRAC_SCALE);
                        state_ff     <= DEC_MUL;
                     end
                     shbg_pkg::CSR_HEAT_CEILING: begin
                        limit_ff <= csr_wdata;
                     end
                     default: begin
                        // unmapped index: write dropped
                     end
                  endcase
               end
            end
            DEC_MUL: begin
               state_ff <= DEC_FIX;
            end
            DEC_FIX: begin
               state_ff <= DEC_IDLE;
            end
            default: begin
               state_ff <= DEC_IDLE;
            end
         endcase
      end
   end

   shbg_cdiv #(
      .WIDTH   (PROD_W),
      .DIVISOR (shbg_pkg::TICKS_PER_SEC)
   ) u_decay_div (
      .clock    (clock),
      .en_mul   (state_ff == DEC_MUL),
      .en_fix   (state_ff == DEC_FIX),
      .dividend (cool_prod_ff),
      .quotient (decay_q)
   );

   assign cfg.target_speed = target_ff;
   assign cfg.heat_ceiling = limit_ff;
   assign cfg.decay        = shbg_pkg::DECAY_W'(decay_q);

endmodule

// File: design/shbg_heat.sv
// Arm/shot detection and own heat update, one tick per load.
module shbg_heat #(
   parameter int unsigned HEAT_FRAC_SCALE = 200
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  shbg_pkg::item_type                  item,
   input  shbg_pkg::cfg_type                   cfg,
   output logic [shbg_pkg::OWN_HEAT_W-1:0]     own_heat,
   output logic                                shot
);

   localparam int unsigned HW = shbg_pkg::OWN_HEAT_W;
   localparam logic [HW:0] SHOT_INC = (HW + 1)'(shbg_pkg::SHOT_HEAT * HEAT_FRAC_SCALE);
   localparam logic signed [17:0] WIN = 18'(shbg_pkg::ARM_WINDOW);

   logic [HW-1:0]       own_heat_ff, own_heat_in;
   logic                armed_ff, armed_in;
   logic                shot_ff;

   logic signed [16:0]  speed_x;
   logic [16:0]         mag;
   logic signed [17:0]  diff;
   logic                near;
   logic                armed_mid;
   logic [19:0]         mag_scaled;
   logic [19:0]         tgt_scaled;
   logic                hit;
   logic [HW:0]         heat_sum;
   logic [HW-1:0]       heat_sat;
   logic [HW-1:0]       decay_w;

   always_comb begin
      speed_x    = {item.speed[shbg_pkg::SPEED_W-1], item.speed};
      // -32768 gives 32768, still exact in 17 bits
      mag        = speed_x[16] ? 17'(-speed_x) : 17'(speed_x);
      diff       = $signed({3'b000, cfg.target_speed}) - $signed({1'b0, mag});
      near       = (diff < WIN) && (diff > -WIN);
      armed_mid  = item.enabled && (armed_ff || near);
      mag_scaled = 20'(mag) * 20'(shbg_pkg::SHOT_DEN);
      tgt_scaled = 20'(cfg.target_speed) * 20'(shbg_pkg::SHOT_NUM);
      hit        = armed_mid && (mag_scaled < tgt_scaled);
      armed_in   = armed_mid && !hit;

      heat_sum    = {1'b0, own_heat_ff} + (hit ? SHOT_INC : '0);
      heat_sat    = heat_sum[HW] ? '1 : heat_sum[HW-1:0];
      decay_w     = HW'(cfg.decay);
      own_heat_in = (heat_sat >= decay_w) ? heat_sat - decay_w : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_heat_ff <= '0;
         armed_ff    <= 1'b0;
      end else if (load) begin
         own_heat_ff <= own_heat_in;
         armed_ff    <= armed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         shot_ff <= hit;
      end
   end

   assign own_heat = own_heat_ff;
   assign shot     = shot_ff;

endmodule

// File: design/shot_heat_budget_gate_top.sv
// Top level of the shot heat budget gate: stream ports, pipeline and config.

// Shot heat budget gate. Each req transfer is one 5 ms control tick carrying
// the wheel enable, the signed left wheel speed and the referee heat; each
// tick yields exactly one rsp transfer with the effective heat, the fire
// permission and a flag for a shot counted on that tick. Throughput is one
// tick per clock when neither the cooling precompute nor rsp stalls it. A
// tick passes the input register, heat update, reciprocal multiply, quotient
// correction and output register. Own heat lives in the heat update stage,
// so ticks are processed strictly in order. Per-tick cooling (cooling_rate *
// scale / 200) is precomputed after reset and after every cooling_rate
// write; meanwhile csr_ready is low and a tick held in the input register
// waits. Registers: index 0 target_speed, 1 cooling_rate, 2 heat ceiling;
// index 3 is ignored. Write configuration only while no tick is in flight.
`include "shot_heat_budget_gate_top_defines.svh"

module shot_heat_budget_gate_top #(
   parameter int unsigned HEAT_FRAC_SCALE = 200
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: [0] wheel_enabled, [16:1] wheel_speed (signed),
   //            [32:17] referee_heat, [39:33] zero
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [shbg_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // rsp_tdata: [15:0] effective_heat, [16] fire_permitted,
   //            [17] shot_detected, [23:18] zero
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [shbg_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [shbg_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [shbg_pkg::COOL_W-1:0]          csr_wdata
);

   localparam int unsigned HW    = shbg_pkg::OWN_HEAT_W;
   localparam int unsigned RW    = shbg_pkg::HEAT_W;
   localparam int unsigned PAD_W = shbg_pkg::RSP_TDATA_W - RW - 2;

   shbg_pkg::cfg_type   cfg;
   logic                busy;

   // stage valids: input, heat, multiply, correct, output
   logic in_valid_ff,   in_valid_in;
   logic heat_valid_ff, heat_valid_in;
   logic mul_valid_ff,  mul_valid_in;
   logic div_valid_ff,  div_valid_in;
   logic rsp_valid_ff,  rsp_valid_in;

   logic rdy_out, rdy_div, rdy_mul, rdy_heat, rdy_in;
   logic load_in, load_heat, load_mul, load_div, load_out;

   shbg_pkg::item_type  item_ff;
   logic [RW-1:0]       ref_heat_ff, ref_mul_ff, ref_div_ff;
   logic                shot_mul_ff, shot_div_ff;
   logic [RW-1:0]       eff_ff, eff_in;
   logic                fire_ff, fire_in;
   logic                shot_out_ff;

   logic [HW-1:0]       own_heat;
   logic                shot_heat;
   logic [HW-1:0]       own_q;
   logic [RW-1:0]       own_sat;

   // ----------------------------------------------------------------------
   // Flow control: each stage moves when it is empty or its successor moves,
   // so the input keeps taking ticks while a result waits at rsp.
   // ----------------------------------------------------------------------
   always_comb begin
      rdy_out   = !rsp_valid_ff || rsp_tready;
      rdy_div   = !div_valid_ff || rdy_out;
      rdy_mul   = !mul_valid_ff || rdy_div;
      rdy_heat  = !heat_valid_ff || rdy_mul;
      // heat update waits for a fresh cooling amount
      load_heat = in_valid_ff && rdy_heat && !busy;
      rdy_in    = !in_valid_ff || load_heat;
      load_in   = req_tvalid && rdy_in;
      load_mul  = heat_valid_ff && rdy_mul;
      load_div  = mul_valid_ff && rdy_div;
      load_out  = div_valid_ff && rdy_out;

      in_valid_in   = load_in   || (in_valid_ff   && !load_heat);
      heat_valid_in = load_heat || (heat_valid_ff && !load_mul);
      mul_valid_in  = load_mul  || (mul_valid_ff  && !load_div);
      div_valid_in  = load_div  || (div_valid_ff  && !load_out);
      rsp_valid_in  = load_out  || (rsp_valid_ff  && !rsp_tready);
   end

   assign req_tready = rdy_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         heat_valid_ff <= 1'b0;
         mul_valid_ff  <= 1'b0;
         div_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         heat_valid_ff <= heat_valid_in;
         mul_valid_ff  <= mul_valid_in;
         div_valid_ff  <= div_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // ----------------------------------------------------------------------
   // Payload registers
   // ----------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (load_in) begin
         item_ff.enabled      <= req_tdata[0];
         item_ff.speed        <= req_tdata[16:1];
         item_ff.referee_heat <= req_tdata[32:17];
      end
      if (load_heat) begin
         ref_heat_ff <= item_ff.referee_heat;
      end
      if (load_mul) begin
         ref_mul_ff  <= ref_heat_ff;
         shot_mul_ff <= shot_heat;
      end
      if (load_div) begin
         ref_div_ff  <= ref_mul_ff;
         shot_div_ff <= shot_mul_ff;
      end
      if (load_out) begin
         eff_ff      <= eff_in;
         fire_ff     <= fire_in;
         shot_out_ff <= shot_div_ff;
      end
   end

   shbg_cfg #(
      .HEAT_FRAC_SCALE (HEAT_FRAC_SCALE)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .busy      (busy)
   );

   // own heat register holds the value for the tick in the heat stage
   shbg_heat #(
      .HEAT_FRAC_SCALE (HEAT_FRAC_SCALE)
   ) u_heat (
      .clock    (clock),
      .reset    (reset),
      .load     (load_heat),
      .item     (item_ff),
      .cfg      (cfg),
      .own_heat (own_heat),
      .shot     (shot_heat)
   );

   // own heat in whole units: divide by the fixed-point scale
   shbg_cdiv #(
      .WIDTH   (HW),
      .DIVISOR (HEAT_FRAC_SCALE)
   ) u_heat_div (
      .clock    (clock),
      .en_mul   (load_mul),
      .en_fix   (load_div),
      .dividend (own_heat),
      .quotient (own_q)
   );

   // Saturate to 16 bits, take the larger with referee heat, then gate.
   always_comb begin
      own_sat = (|own_q[HW-1:RW]) ? '1 : own_q[RW-1:0];
      eff_in  = (own_sat > ref_div_ff) ? own_sat : ref_div_ff;
      fire_in = ({2'b00, cfg.heat_ceiling} >=
                 ({2'b00, eff_in} + (RW + 2)'(shbg_pkg::FIRE_MARGIN)));
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {PAD_W'(0), shot_out_ff, fire_ff, eff_ff};

   // ----------------------------------------------------------------------
   // Checks
   // ----------------------------------------------------------------------
   `SHBG_ASSERT_IMPLY(a_no_tick_during_decay_calc, busy, !load_heat)
   `SHBG_ASSERT_IMPLY(a_decay_calc_after_reset, $past(reset), busy)
   `SHBG_ASSERT_NEXT(a_cooling_write_starts_calc,
      csr_valid && csr_ready && (csr_index == shbg_pkg::CSR_COOLING_RATE), busy)
   `SHBG_ASSERT_IMPLY(a_rsp_not_overwritten, rsp_valid_ff && !rsp_tready, !load_out)

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the shot heat budget gate: stream driver, monitor, predictor.
`timescale 1ns / 1ps

module tb_top;

   // Heat scale of the instance under test (its default).
   localparam longint FRAC_SCALE  = 200;
   localparam longint TICK_RATE   = 200;
   localparam longint ARM_SPAN    = 300;
   localparam longint SHOT_STEP   = 100 * FRAC_SCALE;
   localparam longint FIRE_GAP    = 150;
   localparam longint OWN_TOP     = 64'hFF_FFFF;
   localparam longint EFF_TOP     = 64'hFFFF;
   localparam int     LONG_STALL  = 300;
   localparam int     TAIL_CYCLES = 20;
   localparam int     CYCLE_LIMIT = 400000;
   // Index past the register map; writes to it must be dropped.
   localparam logic [shbg_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [shbg_pkg::HEAT_W-1:0] eff_heat;
      logic                        fire_ok;
      logic                        shot;
   } gate_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [shbg_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [shbg_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [shbg_pkg::CSR_IDX_W-1:0]   csr_index = '0;
   logic [shbg_pkg::COOL_W-1:0]      csr_wdata = '0;

   // Predictor copy of the registers and the heat state.
   logic [shbg_pkg::TARGET_W-1:0] cfg_target = shbg_pkg::TARGET_RESET;
   logic [shbg_pkg::COOL_W-1:0]   cfg_cool   = shbg_pkg::COOL_RESET;
   logic [shbg_pkg::HEAT_W-1:0]   cfg_limit  = shbg_pkg::LIMIT_RESET;
   longint                        own_heat   = 0;
   bit                            armed      = 1'b0;

   shbg_pkg::item_type tick_q[$];          // ticks waiting to be offered
   gate_result_type    pending_results[$]; // predicted results, oldest first
   shbg_pkg::item_type cur_tick;

   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   logic        rsp_hold      = 1'b0;
   event        long_stall_go;

   int mismatches   = 0;
   int ticks_sent   = 0;
   int results_seen = 0;
   int shots_seen   = 0;
   int fire_grants  = 0;
   int csr_writes   = 0;
   int cycle_count  = 0;

   shot_heat_budget_gate_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // One control tick through the heat estimate: arm, shot, heat add, cooling, gate.
   function automatic gate_result_type advance_heat(input shbg_pkg::item_type t);
      longint mag;
      longint diff;
      longint heat;
      longint decay;
      longint eff;
      gate_result_type r;
      mag = longint'($signed(t.speed));
      if (mag < 0) mag = -mag;
      diff = longint'(cfg_target) - mag;
      if (diff < 0) diff = -diff;
      r.shot = 1'b0;
      if (t.enabled && diff < ARM_SPAN && !armed) armed = 1'b1;
      if (!t.enabled) armed = 1'b0;
      // arming and the speed drop can land on the same tick
      if (armed && 10 * mag < 9 * longint'(cfg_target)) begin
         armed  = 1'b0;
         r.shot = 1'b1;
      end
      heat = own_heat;
      if (r.shot) heat = heat + SHOT_STEP;
      if (heat > OWN_TOP) heat = OWN_TOP;
      decay = longint'(cfg_cool) * FRAC_SCALE / TICK_RATE;
      heat = (heat >= decay) ? heat - decay : 0;
      own_heat = heat;
      eff = heat / FRAC_SCALE;
      if (eff < longint'(t.referee_heat)) eff = longint'(t.referee_heat);
      if (eff > EFF_TOP) eff = EFF_TOP;
      r.eff_heat = eff[shbg_pkg::HEAT_W-1:0];
      r.fire_ok  = (longint'(cfg_limit) - eff) >= FIRE_GAP;
      return r;
   endfunction

   task automatic queue_tick(input logic en, input logic [shbg_pkg::SPEED_W-1:0] sp,
                             input logic [shbg_pkg::HEAT_W-1:0] rh);
      shbg_pkg::item_type t;
      t.enabled      = en;
      t.speed        = sp;
      t.referee_heat = rh;
      tick_q.push_back(t);
   endtask

   // Mostly near the limit so the fire gate toggles; sometimes anything.
   function automatic logic [shbg_pkg::HEAT_W-1:0] pick_ref_heat();
      longint top;
      top = longint'(cfg_limit) + 50;
      if (top > EFF_TOP) top = EFF_TOP;
      if ($urandom_range(99) < 20) return shbg_pkg::HEAT_W'($urandom_range(65535));
      return shbg_pkg::HEAT_W'($urandom_range(int'(top)));
   endfunction

   function automatic logic [shbg_pkg::SPEED_W-1:0] signed_speed(input longint mag);
      longint v;
      v = ($urandom_range(1) != 0) ? -mag : mag;
      return v[shbg_pkg::SPEED_W-1:0];
   endfunction

   // Spin-up / drop sequences with random content, plus raw noise ticks.
   task automatic queue_mixed(input int n);
      int     left;
      int     k;
      longint sp;
      longint drop_max;
      left = n;
      while (left > 0) begin
         if ($urandom_range(99) < 25) begin
            queue_tick(1'($urandom_range(1)), shbg_pkg::SPEED_W'($urandom_range(65535)),
                       shbg_pkg::HEAT_W'($urandom_range(65535)));
            left--;
         end else begin
            k = int'($urandom_range(1, 4));
            while (k > 0 && left > 0) begin
               sp = longint'(cfg_target) + longint'($urandom_range(598)) - 299;
               if (sp < 0) sp = 0;
               if (sp > 32767) sp = 32767;
               queue_tick(1'b1, signed_speed(sp), pick_ref_heat());
               k--;
               left--;
            end
            drop_max = (cfg_target == 0) ? 0 : (9 * longint'(cfg_target) - 1) / 10;
            k = int'($urandom_range(1, 2));
            while (k > 0 && left > 0) begin
               queue_tick(1'b1, signed_speed(longint'($urandom_range(int'(drop_max)))),
                          pick_ref_heat());
               k--;
               left--;
            end
            if (left > 0 && $urandom_range(99) < 20) begin
               queue_tick(1'b0, shbg_pkg::SPEED_W'($urandom_range(65535)), pick_ref_heat());
               left--;
            end
         end
      end
   endtask

   // Waits until every queued tick is sent and every predicted result has come back.
   task automatic wait_all_results();
      do @(negedge clock);
      while (tick_q.size() != 0 || req_tvalid || pending_results.size() != 0);
   endtask

   // Leaves csr_valid high; the caller lowers it after the last write.
   task automatic csr_put(input logic [shbg_pkg::CSR_IDX_W-1:0] idx,
                          input logic [shbg_pkg::COOL_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock);
      while (!csr_ready);
      case (idx)
         shbg_pkg::CSR_TARGET_SPEED: cfg_target = data[shbg_pkg::TARGET_W-1:0];
         shbg_pkg::CSR_COOLING_RATE: cfg_cool   = data;
         shbg_pkg::CSR_HEAT_CEILING: cfg_limit  = data;
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic set_gate_regs(input logic [shbg_pkg::COOL_W-1:0] target,
                                input logic [shbg_pkg::COOL_W-1:0] cool,
                                input logic [shbg_pkg::COOL_W-1:0] limit,
                                input bit poke_spare);
      @(posedge clock);
      if (poke_spare) csr_put(CSR_SPARE, shbg_pkg::COOL_W'($urandom_range(65535)));
      csr_put(shbg_pkg::CSR_TARGET_SPEED, target);
      csr_put(shbg_pkg::CSR_COOLING_RATE, cool);
      csr_put(shbg_pkg::CSR_HEAT_CEILING, limit);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [shbg_pkg::COOL_W-1:0] target,
                            input logic [shbg_pkg::COOL_W-1:0] cool,
                            input logic [shbg_pkg::COOL_W-1:0] limit,
                            input int unsigned send_pct,
                            input int unsigned stall_pct, input int n, input bit squeeze);
      set_gate_regs(target, cool, limit, 1'($urandom_range(1)));
      @(negedge clock);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      // receiver holds off while the sender keeps pushing: input must back up
      if (squeeze) -> long_stall_go;
      queue_mixed(n / 2);
      wait_all_results();
      queue_mixed(n - n / 2);
      wait_all_results();
   endtask

   // Driver: offers queued ticks, predicts each one at its transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            pending_results.push_back(advance_heat(cur_tick));
            ticks_sent++;
         end
         if (req_tvalid && !req_tready) begin
            // offered tick must stay put until taken
         end else if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            cur_tick = tick_q.pop_front();
            req_tdata  <= {7'b0, cur_tick.referee_heat, cur_tick.speed, cur_tick.enabled};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor: checks every result transfer against the oldest prediction.
   always @(posedge clock) begin : rsp_check
      gate_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (rsp_tdata[17]) shots_seen++;
            if (rsp_tdata[16]) fire_grants++;
            if (pending_results.size() == 0) begin
               $error("result with nothing pending: rsp_tdata %h", rsp_tdata);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_tdata[15:0] !== want.eff_heat) begin
                  $error("effective_heat: expected %0d, got %0d", want.eff_heat,
                         rsp_tdata[15:0]);
                  mismatches++;
               end
               if (rsp_tdata[16] !== want.fire_ok) begin
                  $error("fire_permitted: expected %0d, got %0d", want.fire_ok, rsp_tdata[16]);
                  mismatches++;
               end
               if (rsp_tdata[17] !== want.shot) begin
                  $error("shot_detected: expected %0d, got %0d", want.shot, rsp_tdata[17]);
                  mismatches++;
               end
            end
         end
         rsp_tready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Long receiver hold-off, counted here in clock cycles.
   always begin
      @(long_stall_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (LONG_STALL) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  pending_results.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      int i;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed, reset register values (target 5700, cooling 40, limit 240).
      queue_tick(1'b0, 16'd0, 16'd90);        // limit - heat exactly at the margin
      queue_tick(1'b0, 16'd0, 16'd91);        // one short of the margin
      queue_tick(1'b1, 16'd5700, 16'd0);      // arm at target
      queue_tick(1'b1, 16'd5000, 16'd0);      // drop below 0.9 target: shot
      queue_tick(1'b1, 16'h7FFF, 16'd0);
      queue_tick(1'b1, 16'h8000, 16'hFFFF);   // most negative speed, referee at top
      queue_tick(1'b1, -16'sd5700, 16'd0);    // arm on a reversed wheel
      queue_tick(1'b1, -16'sd1000, 16'd100);  // shot
      queue_tick(1'b1, 16'd5999, 16'd0);      // just inside the arm window
      queue_tick(1'b0, 16'd5999, 16'd0);      // disable drops the arm
      queue_tick(1'b1, 16'd0, 16'd0);         // no shot without arm
      queue_tick(1'b1, 16'd6000, 16'd0);      // window edge, stays unarmed
      queue_tick(1'b1, 16'd0, 16'd0);
      wait_all_results();

      // Small target so arm and shot coincide; max cooling clamps heat at zero.
      // Bit 15 of the target write must be dropped.
      set_gate_regs(16'h8000 | 16'd1000, 16'hFFFF, 16'hFFFF, 1'b1);
      @(negedge clock);
      queue_tick(1'b1, 16'd750, 16'd0);
      queue_tick(1'b1, -16'sd750, 16'hFFFF);
      queue_tick(1'b1, 16'd899, 16'd1000);
      queue_tick(1'b1, 16'd900, 16'd0);       // arms, 9/10 boundary is not a shot
      queue_tick(1'b0, 16'd900, 16'd0);
      queue_tick(1'b1, 16'd1299, 16'd0);
      queue_tick(1'b1, 16'd500, 16'd149);
      wait_all_results();

      run_phase(16'd5700, 16'd40, 16'd240, 0, 0, 150, 1'b0);
      run_phase(16'hFFFF, 16'd1, 16'hFFFF, 52, 0, 130, 1'b0);
      run_phase(16'd0, 16'hFFFF, 16'd0, 0, 52, 110, 1'b0);
      run_phase(shbg_pkg::COOL_W'($urandom_range(65535)),
                shbg_pkg::COOL_W'($urandom_range(65535)),
                shbg_pkg::COOL_W'($urandom_range(65535)), 17, 17, 130, 1'b0);

      // Shot on nearly every tick (every 25th is random noise) with no cooling: own
      // heat saturates and so does the effective heat.
      set_gate_regs(16'd1000, 16'd0, 16'hFFFF, 1'b0);
      @(negedge clock);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      for (i = 0; i < 920; i++) begin
         if (i % 25 == 24)
            queue_tick(1'($urandom_range(1)), shbg_pkg::SPEED_W'($urandom_range(65535)),
                       shbg_pkg::HEAT_W'($urandom_range(65535)));
         else
            queue_tick(1'b1, signed_speed(longint'($urandom_range(701, 899))),
                       pick_ref_heat());
      end
      wait_all_results();

      run_phase(16'd5700, 16'hFFFF, 16'd300, 0, 52, 150, 1'b0);
      run_phase(16'd3000, 16'd200, 16'd1000, 0, 0, 120, 1'b1);
      run_phase(shbg_pkg::COOL_W'($urandom_range(65535)),
                shbg_pkg::COOL_W'($urandom_range(65535)),
                shbg_pkg::COOL_W'($urandom_range(65535)), 52, 0, 100, 1'b0);

      wait_all_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Covered %0d ticks and %0d checked results (%0d shots, %0d fire grants)",
               ticks_sent, results_seen, shots_seen, fire_grants);
      $display("across %0d register transfers, idle/stall mixes and a long output stall",
               csr_writes);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d results never seen", mismatches,
                  pending_results.size());
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
